// File: rtl/core/qph_pkg.sv
// ----------------------------------------------------------------------------
// qph_pkg
// Shared sizes, operation codes and the command record passed from the
// front part to the back part of the quadratic probe hash table.
// ----------------------------------------------------------------------------
package qph_pkg;

    localparam int TABLE_SIZE  = 16;
    localparam int SLOT_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W       = 31;
    localparam int OP_W        = 2;
    localparam int SLOT_FLD_W  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_SEARCH,
        CMD_DELETE,
        CMD_NOP
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op           op;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] home;
    } t_cmd;

    function automatic logic [SLOT_FLD_W-1:0] slot_field(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W+SLOT_FLD_W-1:0] wide;
        wide = {{SLOT_FLD_W{1'b0}}, slot};
        return wide[SLOT_FLD_W-1:0];
    endfunction

endpackage

// File: rtl/core/qph_ram.sv
// ----------------------------------------------------------------------------
// qph_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module qph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/qph_front.sv
// ----------------------------------------------------------------------------
// qph_front
// Accepts requests, decodes the operation and takes the home slot from the
// low key bits, then pushes the command into the queue.
// ----------------------------------------------------------------------------
module qph_front import qph_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [OP_W-1:0]  i_op,
    input  logic [KEY_W-1:0] i_key_value,
    input  logic             i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_PUSH = 2'b10
    } t_fstate;

    t_fstate           r_state, n_state;
    t_cmd_op           r_op;
    logic [KEY_W-1:0]  r_key;
    logic [SLOT_W-1:0] r_home, n_home;
    logic              accept;
    t_cmd_op           dec_op;

    always_comb begin
        case (i_op)
            OP_INSERT: dec_op = CMD_INSERT;
            OP_SEARCH: dec_op = CMD_SEARCH;
            OP_DELETE: dec_op = CMD_DELETE;
            default:   dec_op = CMD_NOP;
        endcase
    end

    assign n_home = SLOT_W'(i_key_value % KEY_W'(TABLE_SIZE));

    assign accept     = (r_state == F_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_cmd      = '{op: r_op, key: r_key, home: r_home};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_in_valid) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= dec_op;
            r_key  <= i_key_value;
            r_home <= n_home;
        end
    end

endmodule

// File: rtl/core/qph_fifo.sv
// ----------------------------------------------------------------------------
// qph_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module qph_fifo import qph_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_empty,
    output logic o_full,
    output t_cmd o_head
);

    t_cmd              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head  = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= ptr_next(r_wptr);
            if (i_pop)  r_rptr <= ptr_next(r_rptr);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wptr] <= i_cmd;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");
`endif

endmodule

// File: rtl/core/qph_back.sv
// ----------------------------------------------------------------------------
// qph_back
// Walks the quadratic probe sequence one slot per cycle against the key
// RAM and valid bits, updates the table and registers the result.
// ----------------------------------------------------------------------------
module qph_back import qph_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_cmd                  i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_status,
    output logic [SLOT_FLD_W-1:0] o_slot_index
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_PROBE = 3'b010,
        B_DRAIN = 3'b100
    } t_bstate;

    localparam logic [SLOT_W:0] N_EXT = (SLOT_W + 1)'(TABLE_SIZE);

    t_bstate               r_state;
    t_cmd_op               r_op;
    logic [KEY_W-1:0]      r_key;
    logic [SLOT_W-1:0]     r_addr, r_step, r_cnt, n_addr, n_step;
    logic                  r_chk_vld, r_chk_valid;
    logic [SLOT_W-1:0]     r_chk_slot;
    logic [TABLE_SIZE-1:0] r_slot_valid;
    logic                  r_out_valid, r_status;
    logic [SLOT_FLD_W-1:0] r_slot_index;
    logic [KEY_W-1:0]      ram_rdata;
    logic [SLOT_W:0]       addr_sum, step_sum;
    logic                  hit, finish, out_free, last_probe, ram_we, produce;

    always_comb begin
        addr_sum = {1'b0, r_addr} + {1'b0, r_step};
        addr_sum = (addr_sum >= N_EXT) ? addr_sum - N_EXT : addr_sum;
        n_addr   = addr_sum[SLOT_W-1:0];
        step_sum = {1'b0, r_step} + (SLOT_W + 1)'(2);
        step_sum = (step_sum >= N_EXT) ? step_sum - N_EXT : step_sum;
        n_step   = step_sum[SLOT_W-1:0];
    end

    assign hit = r_chk_vld && ((r_op == CMD_INSERT) ? !r_chk_valid
                                : (r_chk_valid && (ram_rdata == r_key)));
    assign finish     = ((r_state == B_PROBE) && hit) || (r_state == B_DRAIN);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == B_IDLE) && !i_empty && out_free;
    assign last_probe = (r_cnt == SLOT_W'(TABLE_SIZE - 1));
    assign ram_we     = finish && hit && (r_op == CMD_INSERT);
    assign produce    = finish || (o_pop && (i_head.op == CMD_NOP));

    qph_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_chk_slot),
        .i_wdata (r_key),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_chk_vld    <= 1'b0;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    r_chk_vld <= 1'b0;
                    if (o_pop && (i_head.op != CMD_NOP)) begin
                        r_state <= B_PROBE;
                    end
                end
                B_PROBE: begin
                    r_chk_vld <= !hit;
                    if (hit) begin
                        r_state <= B_IDLE;
                    end else if (last_probe) begin
                        r_state <= B_DRAIN;
                    end
                end
                B_DRAIN: begin
                    r_state   <= B_IDLE;
                    r_chk_vld <= 1'b0;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
            if (finish && hit) begin
                if (r_op == CMD_INSERT) r_slot_valid[r_chk_slot] <= 1'b1;
                if (r_op == CMD_DELETE) r_slot_valid[r_chk_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op   <= i_head.op;
            r_key  <= i_head.key;
            r_addr <= i_head.home;
            r_step <= SLOT_W'(1);
            r_cnt  <= '0;
            if (i_head.op == CMD_NOP) begin
                r_status     <= STATUS_MISS;
                r_slot_index <= '0;
            end
        end else if (r_state == B_PROBE) begin
            r_addr <= n_addr;
            r_step <= n_step;
            r_cnt  <= r_cnt + 1'b1;
        end
        if (r_state == B_PROBE) begin
            r_chk_slot  <= r_addr;
            r_chk_valid <= r_slot_valid[r_addr];
        end
        if (finish) begin
            r_status     <= hit ? STATUS_OK : STATUS_MISS;
            r_slot_index <= hit ? slot_field(r_chk_slot) : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_slot_index;

`ifndef NO_ASSERTIONS
    a_insert_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && hit && r_op == CMD_INSERT) |=> r_slot_valid[$past(r_chk_slot)])
        else $error("insert did not mark its slot");
    a_delete_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && hit && r_op == CMD_DELETE) |=> !r_slot_valid[$past(r_chk_slot)])
        else $error("delete did not free its slot");
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_IDLE) |-> ({1'b0, r_addr} < N_EXT))
        else $error("probe address out of range");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_MISS) |-> (o_slot_index == '0))
        else $error("miss result with nonzero slot");
`endif

endmodule

// File: rtl/core/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing hash table with quadratic probing: insert, search and
// delete of 31-bit keys over TABLE_SIZE slots.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid/o_in_stall   i_op, i_key_value
//   out      output     o_out_valid/i_out_stall o_status, o_slot_index
//
// Front: one request at a time (accept with the home slot taken from the low
// key bits, queue push). Back: the unused code gives a miss without probing;
// the others probe one slot per cycle through the registered key RAM.
// Sustained rate is set by the back.
// Synchronous active-low reset clears all valid bits at once.
// A stalled output holds the result; the two-entry queue keeps the front busy.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table import qph_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_op,
    input  logic [KEY_W-1:0]      i_key_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_status,
    output logic [SLOT_FLD_W-1:0] o_slot_index
);

    t_cmd push_cmd, head_cmd;
    logic push, pop, q_empty, q_full;

    qph_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_key_value (i_key_value),
        .i_full      (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    qph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_head  (head_cmd)
    );

    qph_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_slot_index (o_slot_index)
    );

endmodule

// File: sim/tb_quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// tb_quadratic_probe_hash_table
// Self-checking bench for the quadratic probe hash table. A shadow table
// predicts the status and slot of every accepted request. Directed cases
// fill the table, hit the full and missing-key cases and reuse a freed slot.
// Random mixes of insert, search, delete and the unused code follow, with
// random idling on both sides, a long output hold-off and a no-idle burst.
// ----------------------------------------------------------------------------
module tb_quadratic_probe_hash_table;
    import qph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic                  status;
        logic [SLOT_FLD_W-1:0] slot;
    } t_table_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_op = '0;
    logic [KEY_W-1:0]      i_key_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_status;
    logic [SLOT_FLD_W-1:0] o_slot_index;

    logic [KEY_W-1:0] stored_keys [TABLE_SIZE];
    logic             occupied    [TABLE_SIZE] = '{default: 1'b0};
    t_table_reply     pending_replies [$];
    logic [KEY_W-1:0] resident_keys [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  flat_out = 1'b0;

    quadratic_probe_hash_table u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_key_value  (i_key_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_slot_index (o_slot_index)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("quadratic_probe_hash_table regression: fail");
            $finish;
        end
    end

    function automatic t_table_reply apply_table_op(input logic [OP_W-1:0] op,
                                                    input logic [KEY_W-1:0] key);
        t_table_reply      reply;
        int                hit;
        logic [SLOT_W-1:0] s;
        hit = -1;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            s = SLOT_W'((longint'(key) + longint'(i * i)) % TABLE_SIZE);
            if (hit < 0) begin
                case (op)
                    OP_INSERT: begin
                        if (!occupied[s]) hit = int'(s);
                    end
                    OP_SEARCH, OP_DELETE: begin
                        if (occupied[s] && stored_keys[s] == key) hit = int'(s);
                    end
                    default: ;
                endcase
            end
        end
        if (hit >= 0) begin
            if (op == OP_INSERT) begin
                stored_keys[hit] = key;
                occupied[hit] = 1'b1;
            end else if (op == OP_DELETE) begin
                occupied[hit] = 1'b0;
            end
            reply.status = STATUS_OK;
            reply.slot = SLOT_FLD_W'(hit);
        end else begin
            reply.status = STATUS_MISS;
            reply.slot = '0;
        end
        return reply;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        t_table_reply reply;
        while (!flat_out && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_key_value <= key;
        do @(posedge i_clk); while (o_in_stall);
        reply = apply_table_op(op, key);
        pending_replies.push_back(reply);
        if (reply.status == STATUS_OK) begin
            if (op == OP_INSERT) begin
                resident_keys.push_back(key);
            end else if (op == OP_DELETE) begin
                for (int i = 0; i < resident_keys.size(); i++) begin
                    if (resident_keys[i] == key) begin
                        resident_keys.delete(i);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic send_random_request();
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        int               r;
        r = $urandom_range(99);
        if (r < 38) op = OP_INSERT;
        else if (r < 68) op = OP_SEARCH;
        else if (r < 95) op = OP_DELETE;
        else op = OP_UNUSED;
        r = $urandom_range(99);
        if (r < 50 && resident_keys.size() > 0)
            key = resident_keys[$urandom_range(resident_keys.size() - 1)];
        else if (r < 75)
            key = KEY_W'($urandom_range(63));
        else
            key = KEY_W'($urandom);
        send_request(op, key);
    endtask

    always @(posedge i_clk) begin
        t_table_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d",
                         $time, o_status, o_slot_index);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_slot_index !== want.slot) begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, o_slot_index);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= flat_out ? 1'b0 : ($urandom_range(99) < 32);
        end
    end

    task automatic test_directed();
        // fill every slot once, so no probe ever sees an unwritten key
        for (int i = 0; i < TABLE_SIZE - 1; i++)
            send_request(OP_INSERT, (KEY_W'(i) << 26) | KEY_W'(i));
        send_request(OP_INSERT, {KEY_W{1'b1}});
        send_request(OP_INSERT, 31'h1234_5678);
        send_request(OP_SEARCH, {KEY_W{1'b1}});
        send_request(OP_SEARCH, '0);
        send_request(OP_DELETE, (KEY_W'(5) << 26) | KEY_W'(5));
        send_request(OP_SEARCH, (KEY_W'(5) << 26) | KEY_W'(5));
        send_request(OP_DELETE, (KEY_W'(5) << 26) | KEY_W'(5));
        send_request(OP_INSERT, 31'd21);
        send_request(OP_UNUSED, {KEY_W{1'b1}});
        send_request(OP_SEARCH, 31'h5555_5555);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random_request();
    endtask

    task automatic test_output_hold();
        @(negedge i_clk);
        hold_left = 300;
        repeat (40) send_random_request();
    endtask

    task automatic test_streaming();
        @(negedge i_clk);
        flat_out = 1'b1;
        repeat (80) send_random_request();
        @(negedge i_clk);
        flat_out = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_mix(200);
        test_output_hold();
        test_streaming();
        test_random_mix(80);
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("quadratic_probe_hash_table regression: pass");
        end else begin
            $display("quadratic_probe_hash_table regression: fail");
        end
        $finish;
    end

endmodule

// File: quadratic_probe_hash_table.f
rtl/core/qph_pkg.sv
rtl/core/qph_ram.sv
rtl/core/qph_front.sv
rtl/core/qph_fifo.sv
rtl/core/qph_back.sv
rtl/core/quadratic_probe_hash_table.sv
sim/tb_quadratic_probe_hash_table.sv
